// File: rtl/tcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared widths, controller states and command/status structs for the
// touch group centroid block.
// ----------------------------------------------------------------------------
package tcg_pkg;

  localparam int CH_COUNT_DEF     = 8;
  localparam int REG_COUNT        = 8;
  localparam int VALUE_W          = 8;
  localparam int MASK_W           = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int AVG_W            = 16;
  localparam int COUNT_W          = 4;
  localparam int SUM_W            = 11;
  localparam int FRAC_W           = 8;
  localparam int DIV_W            = SUM_W + FRAC_W;
  localparam int STEP_W           = $clog2(DIV_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic scan;
    logic div_start;
    logic set_release;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic accepted;
    logic scan_done;
    logic count_zero;
    logic new_touch;
    logic held;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/tcg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_in_if
// Sample channel: one touch mask per item.
// ----------------------------------------------------------------------------
interface tcg_in_if;
  logic                         valid;
  logic                         ready;
  logic [tcg_pkg::MASK_W-1:0]   active_mask;

  modport source (output valid, output active_mask, input ready);
  modport sink   (input valid, input active_mask, output ready);
endinterface

// File: rtl/tcg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_out_if
// Result channel: touch average or release event.
// ----------------------------------------------------------------------------
interface tcg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         released;
  logic [tcg_pkg::AVG_W-1:0]    average;
  logic [tcg_pkg::COUNT_W-1:0]  active_count;

  modport source (output valid, output released, output average, output active_count,
                  input ready);
  modport sink   (input valid, input released, input average, input active_count,
                  output ready);
endinterface

// File: rtl/tcg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcg_pkg::CFG_IDX_W-1:0]  index;
  logic [tcg_pkg::VALUE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/tcg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_ctrl
// Sequencer: scan the channels, decide, run the divider, emit.
// ----------------------------------------------------------------------------
module tcg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  tcg_pkg::status_t status,
  output tcg_pkg::cmd_t    cmd
);
  import tcg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.accepted) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.count_zero && status.new_touch) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else if (status.count_zero && status.held) begin
          cmd.set_release = 1'b1;
          state_nxt       = ST_EMIT;
        end else begin
          // nothing changed: drop the item
          state_nxt = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tcg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_dp
// Datapath: channel value registers, serial sum and count, restoring
// divider, touch state and the output register.
// ----------------------------------------------------------------------------
module tcg_dp #(
  parameter int CH_COUNT = tcg_pkg::CH_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tcg_in_if.sink           in_ch,
  tcg_out_if.source        out_ch,
  tcg_cfg_if.sink          cfg_ch,
  input  tcg_pkg::cmd_t    cmd,
  output tcg_pkg::status_t status
);
  import tcg_pkg::*;

  localparam int USED  = (CH_COUNT < REG_COUNT) ? CH_COUNT : REG_COUNT;
  localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

  logic [VALUE_W-1:0] value_r [USED];
  logic [USED-1:0]    mask_r;
  logic [USED-1:0]    rep_r;
  logic               held_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [COUNT_W-1:0] count_r;
  logic [DIV_W-1:0]   q_r;
  logic [COUNT_W-1:0] rem_r;
  logic [STEP_W-1:0]  step_r;
  logic               rel_r;

  logic               out_valid_r;
  logic               out_rel_r;
  logic [AVG_W-1:0]   out_avg_r;
  logic [COUNT_W-1:0] out_cnt_r;

  logic               accepted;
  logic               cfg_hit;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               ge;

  assign accepted     = in_ch.valid && cmd.take;
  assign in_ch.ready  = cmd.take;
  assign cfg_ch.ready = 1'b1;
  assign cfg_hit      = cfg_ch.valid &&
                        ({1'b0, cfg_ch.index} < (CFG_IDX_W + 1)'(USED));

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, count_r};
  assign ge    = (trial >= {1'b0, count_r});

  assign status.accepted   = accepted;
  assign status.scan_done  = (idx_r == IDX_W'(USED - 1));
  assign status.count_zero = (count_r == '0);
  assign status.new_touch  = (mask_r != rep_r) || !held_r;
  assign status.held       = held_r;
  assign status.div_done   = (step_r == STEP_W'(DIV_W - 1));
  assign status.out_free   = !out_valid_r || out_ch.ready;

  // Channel value registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USED; i++) begin
        value_r[i] <= VALUE_W'(i);
      end
    end else if (cfg_hit) begin
      value_r[cfg_ch.index[IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  // Touch state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      rep_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
      if (rel_r) begin
        held_r <= 1'b0;
      end else begin
        // the reported mask only follows touches
        held_r <= 1'b1;
        rep_r  <= mask_r;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Scan, divide and output payload
  always_ff @(posedge clk) begin
    if (accepted) begin
      mask_r  <= in_ch.active_mask[USED-1:0];
      idx_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end
    if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      if (mask_r[idx_r]) begin
        sum_r   <= sum_r + SUM_W'(value_r[idx_r]);
        count_r <= count_r + 1'b1;
      end
    end
    if (cmd.div_start) begin
      q_r    <= {sum_r, {FRAC_W{1'b0}}};
      rem_r  <= '0;
      step_r <= '0;
      rel_r  <= 1'b0;
    end
    if (cmd.set_release) begin
      rel_r <= 1'b1;
    end
    if (cmd.div_step) begin
      // one quotient bit per cycle, remainder stays below the count
      q_r    <= {q_r[DIV_W-2:0], ge};
      rem_r  <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      step_r <= step_r + 1'b1;
    end
    if (cmd.emit) begin
      out_rel_r <= rel_r;
      out_avg_r <= rel_r ? '0 : q_r[AVG_W-1:0];
      out_cnt_r <= rel_r ? '0 : count_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.released     = out_rel_r;
  assign out_ch.average      = out_avg_r;
  assign out_ch.active_count = out_cnt_r;

endmodule

// File: rtl/touch_group_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_group_centroid
// Averages the configured values of the active touch channels per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one active_mask per item; ready is high only while the
//           sequencer is idle.
//   out_ch  carries a touch result (released=0, 8.8 average, active_count)
//           or a release event (released=1, other fields zero).
//   cfg_ch  writes value_chI at index I; always ready. Write only when idle.
// Sequence, with U = min(CH_COUNT, 8) channels scanned one per cycle:
//   - every item is scanned serially, then decided; one that yields no result
//     is then dropped; a release goes straight to the emit step; a touch result
//     first runs the 19-step restoring divider.
//   The next item is accepted only once the block is back in idle.
// Reset: channel values return to I, no touch held, reported mask zero,
//   output empty.
// Stall: the result sits in the output register; an item that needs to
//   emit waits in the emit step until that register is taken.
// ----------------------------------------------------------------------------
module touch_group_centroid #(
  parameter int CH_COUNT = tcg_pkg::CH_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcg_in_if.sink    in_ch,
  tcg_out_if.source out_ch,
  tcg_cfg_if.sink   cfg_ch
);
  import tcg_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcg_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  tcg_dp #(
    .CH_COUNT (CH_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule

// File: tb/touch_group_centroid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_group_centroid_tb
// Drives touch masks and channel values into the centroid block and checks
// every touch average and release event against a cycle-free prediction,
// under random sender bursts and receiver stalls across several settings.
// ----------------------------------------------------------------------------
module touch_group_centroid_tb;
  import tcg_pkg::*;

  localparam int SEL_W = $clog2(MASK_W);

  typedef struct packed {
    logic               released;
    logic [AVG_W-1:0]   average;
    logic [COUNT_W-1:0] active_count;
  } centroid_t;

  class centroid_predictor;
    logic [VALUE_W-1:0] channel_value[REG_COUNT];
    logic [MASK_W-1:0]  reported_mask;
    bit                 touch_held;
    centroid_t          expected_results[$];
    int                 mismatch_count;

    function new();
      for (int i = 0; i < REG_COUNT; i++) channel_value[i] = VALUE_W'(i);
      reported_mask  = '0;
      touch_held     = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_channel_value(int idx, logic [VALUE_W-1:0] v);
      if (idx < REG_COUNT) channel_value[idx] = v;
    endfunction

    // Returns 1 when the sample causes a result.
    function bit note_sample(logic [MASK_W-1:0] bits);
      int unsigned       sum;
      int unsigned       count;
      logic [MASK_W-1:0] mask;
      centroid_t         r;
      sum   = 0;
      count = 0;
      mask  = '0;
      for (int i = 0; i < CH_COUNT_DEF && i < REG_COUNT; i++) begin
        if (bits[i]) begin
          mask[i] = 1'b1;
          sum     += channel_value[i];
          count++;
        end
      end
      if (count != 0) begin
        if (mask != reported_mask || !touch_held) begin
          touch_held     = 1'b1;
          reported_mask  = mask;
          r.released     = 1'b0;
          r.average      = AVG_W'((sum << FRAC_W) / count);
          r.active_count = COUNT_W'(count);
          expected_results = {expected_results, r};
          return 1'b1;
        end
        return 1'b0;
      end
      if (touch_held) begin
        // release leaves the reported mask alone
        touch_held = 1'b0;
        r = '0;
        r.released = 1'b1;
        expected_results = {expected_results, r};
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(centroid_t got);
      centroid_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result released=%0d average=%0d count=%0d",
                 $time, got.released, got.average, got.active_count);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      if (want.released !== got.released) begin
        $display("%0t: released expected %0d actual %0d", $time, want.released, got.released);
        mismatch_count++;
      end
      if (want.average !== got.average) begin
        $display("%0t: average expected 0x%04h actual 0x%04h", $time, want.average, got.average);
        mismatch_count++;
      end
      if (want.active_count !== got.active_count) begin
        $display("%0t: active_count expected %0d actual %0d",
                 $time, want.active_count, got.active_count);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcg_in_if  in_bus();
  tcg_out_if out_bus();
  tcg_cfg_if cfg_bus();

  touch_group_centroid dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  centroid_predictor sb;

  logic [VALUE_W-1:0] chan_cfg[REG_COUNT];
  int burst_left = 0;
  int burst_max  = 64;
  int gap_max    = 0;
  int stall_pct  = 0;
  int stall_max  = 1;
  int stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result receiver: check each accepted item, then stall on its own pattern.
  always @(posedge clk) begin : rx
    centroid_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.released     = out_bus.released;
      got.average      = out_bus.average;
      got.active_count = out_bus.active_count;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, stall_max);
    end
  end

  // Send one mask; leave valid high so the next item may follow directly.
  task automatic send_sample(input logic [MASK_W-1:0] mask, output bit produced);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid       <= 1'b1;
    in_bus.active_mask <= mask;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    produced = sb.note_sample(mask);
  endtask

  // Drop valid, wait out all results and the tail of a silent item.
  task automatic settle();
    int n;
    n = 0;
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() > 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.mismatch_count += sb.pending();
      sb.expected_results.delete();
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic load_channel_values();
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= CFG_IDX_W'(i);
      cfg_bus.data  <= chan_cfg[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      sb.set_channel_value(i, chan_cfg[i]);
    end
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_list(input logic [MASK_W-1:0] masks[$]);
    bit produced;
    foreach (masks[i]) send_sample(masks[i], produced);
  endtask

  // Mostly touch, hold, slide, release sequences; the rest random masks.
  task automatic run_touch_stream(input int results_wanted);
    int                got;
    int                holds;
    bit                produced;
    logic [MASK_W-1:0] m;
    logic [SEL_W-1:0]  flip;
    got = 0;
    while (got < results_wanted) begin
      if ($urandom_range(0, 99) < 70) begin
        m = MASK_W'($urandom_range(1, 255));
        holds = $urandom_range(1, 5);
        for (int h = 0; h < holds; h++) begin
          if ($urandom_range(0, 99) < 40) begin
            flip = SEL_W'($urandom_range(0, MASK_W - 1));
            m[flip] ^= 1'b1;
            if (m == '0) begin
              flip = SEL_W'($urandom_range(0, MASK_W - 1));
              m[flip] = 1'b1;
            end
          end
          send_sample(m, produced);
          got += produced;
        end
        holds = $urandom_range(1, 2);
        for (int h = 0; h < holds; h++) begin
          send_sample('0, produced);
          got += produced;
        end
      end else begin
        send_sample(MASK_W'($urandom_range(0, 255)), produced);
        got += produced;
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.active_mask = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, repeats, release, new touch after release.
    send_list('{8'h00, 8'h01, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
                8'h80, 8'h7F, 8'h55, 8'hAA, 8'h00});
    settle();
    foreach (chan_cfg[i]) chan_cfg[i] = 8'hFF;
    load_channel_values();
    send_list('{8'hFF, 8'h01, 8'h00, 8'h01, 8'h03});
    settle();
    // truncating divide: 1/3 of one step
    foreach (chan_cfg[i]) chan_cfg[i] = 8'hFF;
    chan_cfg[0] = 8'd1;
    chan_cfg[1] = 8'd0;
    chan_cfg[2] = 8'd0;
    load_channel_values();
    send_list('{8'h07, 8'h06, 8'h00});
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          foreach (chan_cfg[i]) chan_cfg[i] = 8'h00;
          stall_pct = 0;  stall_max = 1;  gap_max = 0;  burst_max = 64;
        end
        1: begin
          foreach (chan_cfg[i]) chan_cfg[i] = 8'hFF;
          stall_pct = 30; stall_max = 4;  gap_max = 3;  burst_max = 4;
        end
        2: begin
          foreach (chan_cfg[i]) chan_cfg[i] = VALUE_W'($urandom_range(0, 255));
          stall_pct = 60; stall_max = 40; gap_max = 30; burst_max = 8;
        end
        3: begin
          foreach (chan_cfg[i]) chan_cfg[i] = (i % 2) ? 8'hFF : 8'h00;
          stall_pct = 10; stall_max = 2;  gap_max = 8;  burst_max = 1;
        end
        default: begin
          foreach (chan_cfg[i]) chan_cfg[i] = VALUE_W'($urandom_range(0, 255));
          stall_pct = 50; stall_max = 12; gap_max = 1;  burst_max = 20;
        end
      endcase
      load_channel_values();
      run_touch_stream(56);
      settle();
    end

    repeat (30) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tcg_pkg.sv
rtl/tcg_in_if.sv
rtl/tcg_out_if.sv
rtl/tcg_cfg_if.sv
rtl/tcg_ctrl.sv
rtl/tcg_dp.sv
rtl/touch_group_centroid.sv
tb/touch_group_centroid_tb.sv
